FILE: hdl/frml_pkg.sv
// shared field widths and constants for the frame rate meter and limiter
package frml_pkg;

	// field widths
	localparam int TICK_W     = 32;
	localparam int FT_W       = 32;
	localparam int FPS_W      = 24;
	localparam int DELAY_W    = 18;
	localparam int MAX_FPS_W  = 16;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_PAD_W  = OUT_DATA_W - FT_W - FPS_W - DELAY_W;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MAX_FPS = 1'b0;

	// constants of the rate arithmetic
	localparam logic [MAX_FPS_W-1:0] MAX_FPS_RESET = 16'd15360;
	localparam logic [FPS_W-1:0]     FPS_DEFAULT   = 24'd15360;
	localparam int unsigned          PERIOD_SCALE  = 256000;
	localparam logic [DELAY_W-1:0]   PERIOD_SCALE_D = 18'd256000;

endpackage

FILE: hdl/frame_rate_meter_limiter.sv
// frame rate meter with frame limiter: window sum, iterative divider and sequencer
// Divider width: NUM_W = bits of 256000*WINDOW (22 at WINDOW = 10); one restoring divider,
//   a quotient bit per cycle, runs for the rate and the wait time.
// Requests: a new one is taken only in the idle state, once the last result is handed
//   over; an untaken result holds the next one.
// Reset: arst_n clears control state and history, max_fps returns to 60.0 (Q8.8);
//   the frame window holds no reset value and is only read once written.
module frame_rate_meter_limiter #(
	parameter int WINDOW = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [frml_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [frml_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [frml_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [frml_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // frame_start_ms, now_ms
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [frml_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // frame_time_ms, fps_q8, delay_ms, pad
);
	import frml_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = FT_W + CNT_W;
	localparam int NUM_W  = $clog2(PERIOD_SCALE * WINDOW + 1);
	localparam int BIT_W  = $clog2(NUM_W);
	localparam int PROD_W = TICK_W + MAX_FPS_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_FSET = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DCHK = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]            state_q;
	logic [MAX_FPS_W-1:0]  max_fps_q;
	logic [TICK_W-1:0]     prev_end_q;
	logic                  seen_first_q;
	logic [FT_W-1:0]       win_q [WINDOW];
	logic [SLOT_W-1:0]     slot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [FT_W-1:0]       ft_q;
	logic [TICK_W-1:0]     elapsed_q;
	logic [PROD_W-1:0]     spent_q;
	logic [FPS_W-1:0]      fps_q;
	logic [DELAY_W-1:0]    delay_q;
	logic                  div_mode_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      quo_q;
	logic [SUM_W-1:0]      den_q;
	logic [SUM_W-1:0]      rem_q;
	logic [BIT_W-1:0]      bit_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_valid_q;

	logic                  in_acc;
	logic                  cfg_wr;
	logic [TICK_W-1:0]     in_start;
	logic [TICK_W-1:0]     in_now;
	logic [SUM_W:0]        rem_shift;
	logic [SUM_W:0]        rem_diff;
	logic                  quo_bit;
	logic [NUM_W-1:0]      quo_next;
	logic [FT_W-1:0]       old_ft;
	logic                  win_full;

	assign in_start = s_axis_tdata[TICK_W-1:0];
	assign in_now   = s_axis_tdata[2*TICK_W-1:TICK_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// register port, word-aligned decode
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_FPS);
	assign prdata = (paddr[2] == REG_MAX_FPS) ? APB_DATA_W'(max_fps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fps_q <= MAX_FPS_RESET;
		end else if (cfg_wr) begin
			max_fps_q <= pwdata[MAX_FPS_W-1:0];
		end
	end

	// shared divider step: one restoring quotient bit
	assign rem_shift = {rem_q, num_q[NUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign quo_bit   = !rem_diff[SUM_W];
	assign quo_next  = {quo_q[NUM_W-2:0], quo_bit};

	// oldest frame time in the current slot
	assign old_ft   = win_q[slot_q];
	assign win_full = (cnt_q == CNT_W'(WINDOW));

	// frame window store, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			win_q[slot_q] <= ft_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ft_q      <= seen_first_q ? (in_now - prev_end_q) : '0;
			elapsed_q <= in_now - in_start;
		end
		if (state_q == ST_MUL) begin
			spent_q <= PROD_W'(elapsed_q) * PROD_W'(max_fps_q);
		end
	end

	// sequencer and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_end_q   <= '0;
			seen_first_q <= 1'b0;
			slot_q       <= '0;
			cnt_q        <= '0;
			sum_q        <= '0;
			fps_q        <= '0;
			delay_q      <= '0;
			div_mode_q   <= 1'b0;
			num_q        <= '0;
			quo_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			bit_q        <= '0;
			out_data_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// result leaves when taken, the hand-over state reloads it itself
			if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_end_q   <= in_now;
						seen_first_q <= 1'b1;
						state_q      <= ST_UPD;
					end
				end
				// window sum, count and slot update
				ST_UPD: begin
					sum_q <= sum_q - (win_full ? SUM_W'(old_ft) : '0) + SUM_W'(ft_q);
					if (!win_full) begin
						cnt_q <= cnt_q + 1'b1;
					end
					slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					state_q <= ST_FSET;
				end
				// rate division setup, default rate on an empty sum
				ST_FSET: begin
					if (sum_q == '0) begin
						fps_q   <= FPS_DEFAULT;
						state_q <= ST_MUL;
					end else begin
						num_q      <= NUM_W'(PERIOD_SCALE) * NUM_W'(cnt_q);
						den_q      <= sum_q;
						rem_q      <= '0;
						quo_q      <= '0;
						bit_q      <= BIT_W'(NUM_W - 1);
						div_mode_q <= 1'b0;
						state_q    <= ST_DIV;
					end
				end
				// shared divider iterations
				ST_DIV: begin
					if (quo_bit) begin
						rem_q <= rem_diff[SUM_W-1:0];
					end else begin
						rem_q <= rem_shift[SUM_W-1:0];
					end
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					quo_q <= quo_next;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						if (div_mode_q) begin
							delay_q <= DELAY_W'(quo_next);
							state_q <= ST_FIN;
						end else begin
							fps_q   <= FPS_W'(quo_next);
							state_q <= ST_MUL;
						end
					end
				end
				// elapsed time times target rate
				ST_MUL: begin
					state_q <= ST_DCHK;
				end
				// wait time setup, none when no limit or frame long enough
				ST_DCHK: begin
					if ((max_fps_q == '0) || (spent_q >= PROD_W'(PERIOD_SCALE))) begin
						delay_q <= '0;
						state_q <= ST_FIN;
					end else begin
						num_q      <= NUM_W'(PERIOD_SCALE_D - spent_q[DELAY_W-1:0]);
						den_q      <= SUM_W'(max_fps_q);
						rem_q      <= '0;
						quo_q      <= '0;
						bit_q      <= BIT_W'(NUM_W - 1);
						div_mode_q <= 1'b1;
						state_q    <= ST_DIV;
					end
				end
				// hand over once the output register is free
				ST_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= {{OUT_PAD_W{1'b0}}, delay_q, fps_q, ft_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/sv/frame_rate_meter_limiter_tb.sv
`timescale 1ns / 1ps
// testbench of the frame rate meter and limiter: predicted frame reports checked on the result stream
module frame_rate_meter_limiter_tb;
	import frml_pkg::*;

	localparam int WIN           = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX_FPS = APB_ADDR_W'(4 * REG_MAX_FPS);
	localparam logic [APB_ADDR_W-1:0] ADDR_SPARE   = 3'd4;
	localparam logic [FPS_W-1:0]      FPS_CEILING  = 24'hFFFFFF;

	typedef struct packed {
		logic [FT_W-1:0]    frame_time;
		logic [FPS_W-1:0]   fps;
		logic [DELAY_W-1:0] delay;
	} frame_report_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata;  // frame_start_ms, now_ms
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;  // frame_time_ms, fps_q8, delay_ms, pad

	// predictor state
	logic [MAX_FPS_W-1:0] rate_limit;
	logic [TICK_W-1:0]    last_end;
	logic                 have_first;
	logic [FT_W-1:0]      frame_hist [WIN];
	int                   hist_slot;
	int                   hist_count;
	logic [63:0]          hist_sum;

	frame_report_t pending_reports[$];
	int            fail_count;
	int            cycle_count;
	logic          idle_en;
	logic [TICK_W-1:0] clock_ms;

	frame_rate_meter_limiter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("frame_rate_meter_limiter_tb NOT OK");
			$finish;
		end
	end

	// frame time, windowed rate and limiter wait for one frame end
	function automatic frame_report_t predict_report(input logic [TICK_W-1:0] start_ms,
			input logic [TICK_W-1:0] now_ms);
		frame_report_t rep;
		logic [TICK_W-1:0] elapsed;
		logic [63:0] spent;
		logic [63:0] quot;
		rep.frame_time = have_first ? now_ms - last_end : '0;
		last_end = now_ms;
		have_first = 1'b1;
		// window update, oldest frame dropped once full
		if (hist_count >= WIN)
			hist_sum = hist_sum - frame_hist[hist_slot];
		else
			hist_count = hist_count + 1;
		frame_hist[hist_slot] = rep.frame_time;
		hist_sum = hist_sum + rep.frame_time;
		hist_slot = (hist_slot + 1 >= WIN) ? 0 : hist_slot + 1;
		// averaged rate
		if (hist_sum == 0) begin
			rep.fps = FPS_DEFAULT;
		end else begin
			quot = (64'd256000 * hist_count) / hist_sum;
			rep.fps = (quot > FPS_CEILING) ? FPS_CEILING : quot[FPS_W-1:0];
		end
		// limiter wait
		elapsed = now_ms - start_ms;
		spent = 64'(elapsed) * rate_limit;
		if (rate_limit == 0 || spent >= PERIOD_SCALE)
			rep.delay = '0;
		else
			rep.delay = DELAY_W'((PERIOD_SCALE - spent) / rate_limit);
		return rep;
	endfunction

	// result checker
	always @(posedge clk) begin : check_reports
		frame_report_t want;
		frame_report_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.frame_time = m_axis_tdata[FT_W-1:0];
			got.fps        = m_axis_tdata[FT_W +: FPS_W];
			got.delay      = m_axis_tdata[FT_W+FPS_W +: DELAY_W];
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report ft=%0d fps=%0d delay=%0d", $time,
					got.frame_time, got.fps, got.delay);
				fail_count = fail_count + 1;
			end else begin
				want = pending_reports.pop_front();
				if (got.frame_time !== want.frame_time) begin
					$display("%0t: frame_time_ms expected %0d actual %0d", $time,
						want.frame_time, got.frame_time);
					fail_count = fail_count + 1;
				end
				if (got.fps !== want.fps) begin
					$display("%0t: fps_q8 expected %0d actual %0d", $time, want.fps, got.fps);
					fail_count = fail_count + 1;
				end
				if (got.delay !== want.delay) begin
					$display("%0t: delay_ms expected %0d actual %0d", $time,
						want.delay, got.delay);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	// result side back-pressure, drawn per result
	initial begin : drain_results
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_en ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// one frame end request; called at a falling edge
	task automatic send_frame(input logic [TICK_W-1:0] start_ms, input logic [TICK_W-1:0] now_ms);
		int gap;
		gap = idle_en ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {now_ms, start_ms};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_reports.push_back(predict_report(start_ms, now_ms));
		@(negedge clk);
	endtask

	// stop sending, wait for every report, then let the block go quiet
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_MAX_FPS)
			rate_limit = data[MAX_FPS_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_max_fps_read();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_MAX_FPS;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== APB_DATA_W'(rate_limit)) begin
			$display("%0t: max_fps read expected %0d actual %0d", $time, rate_limit, prdata);
			fail_count = fail_count + 1;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// new limit with junk in the unused upper half of the write data
	task automatic set_rate_limit(input logic [MAX_FPS_W-1:0] value);
		settle_block();
		reg_write(ADDR_MAX_FPS, {16'($urandom), value});
		check_max_fps_read();
	endtask

	// mostly steady frame ends with some wild ones mixed in
	task automatic random_frames(input int count);
		logic [TICK_W-1:0] start_ms;
		int kind;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				start_ms = $urandom;
				clock_ms = $urandom;
			end else begin
				clock_ms = clock_ms + ((kind == 1) ? $urandom_range(0, 100000)
					: $urandom_range(0, 70));
				start_ms = clock_ms - (kind < 6 ? $urandom_range(0, 3) : $urandom_range(0, 40));
			end
			send_frame(start_ms, clock_ms);
		end
	endtask

	// reset value, ignored spare register, read back
	task automatic test_register_access();
		check_max_fps_read();
		reg_write(ADDR_SPARE, $urandom);
		check_max_fps_read();
	endtask

	// first frame, zero sum, wraps, field extremes and window filling at 16 ms frames
	task automatic test_directed_frames();
		idle_en = 1'b1;
		send_frame(32'd0, 32'd0);
		send_frame(32'd0, 32'd0);
		send_frame(32'd10, 32'd16);
		send_frame(32'd16, 32'd33);
		send_frame(32'd17, 32'd33);
		// start after now
		send_frame(32'd40, 32'd33);
		send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// tick wraps between start and end
		send_frame(32'hFFFF_FFF0, 32'd5);
		send_frame(32'd0, 32'hFFFF_FFFF);
		// fill past a full window
		clock_ms = 32'd100;
		for (int i = 0; i < 12; i++) begin
			clock_ms = clock_ms + 16;
			send_frame(clock_ms - 3, clock_ms);
		end
	endtask

	// limiter at no limit, the extremes and 1.0 fps boundary
	task automatic test_rate_limits();
		set_rate_limit(16'd0);
		random_frames(40);
		set_rate_limit(16'd1);
		random_frames(40);
		set_rate_limit(16'hFFFF);
		random_frames(40);
		set_rate_limit(16'd256);
		idle_en = 1'b0;
		clock_ms = clock_ms + 2000;
		send_frame(clock_ms - 1000, clock_ms);
		clock_ms = clock_ms + 2000;
		send_frame(clock_ms - 999, clock_ms);
		clock_ms = clock_ms + 2000;
		send_frame(clock_ms, clock_ms);
		random_frames(40);
	endtask

	// random limits with random frame streams
	task automatic test_random_frames();
		for (int p = 0; p < 4; p++) begin
			set_rate_limit(16'($urandom_range(1, 65535)));
			random_frames(100);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		fail_count    = 0;
		cycle_count   = 0;
		idle_en       = 1'b1;
		clock_ms      = '0;
		rate_limit    = MAX_FPS_RESET;
		last_end      = '0;
		have_first    = 1'b0;
		hist_slot     = 0;
		hist_count    = 0;
		hist_sum      = '0;
		for (int i = 0; i < WIN; i++)
			frame_hist[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_access();
		test_directed_frames();
		test_rate_limits();
		test_random_frames();
		settle_block();

		if (fail_count == 0)
			$display("frame_rate_meter_limiter_tb OK");
		else
			$display("frame_rate_meter_limiter_tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
hdl/frml_pkg.sv
hdl/frame_rate_meter_limiter.sv
tb/sv/frame_rate_meter_limiter_tb.sv
